[rtl/core/dcs_pkg.sv]
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared types, widths, codes and helpers of the distance constraint solver.
// ----------------------------------------------------------------------------
`default_nettype none

package dcs_pkg;

    // Command codes on the input tuser
    localparam logic [1:0] CMD_MOVE_FIRST  = 2'd0;
    localparam logic [1:0] CMD_MOVE_SECOND = 2'd1;
    localparam logic [1:0] CMD_DISTANCE    = 2'd2;
    localparam logic [1:0] CMD_INVALID     = 2'd3;

    // Changed-variable codes on the output tuser
    localparam logic [1:0] VAR_FIRST    = 2'd0;
    localparam logic [1:0] VAR_SECOND   = 2'd1;
    localparam logic [1:0] VAR_DISTANCE = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 63;
    localparam logic [CFG_IDX_W-1:0] REG_GUESS_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GUESS_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GUESS_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = 3'd4;

    localparam int LANES = 3;

    // Square root: 66-bit radicand, 33 root bits, one root bit per iteration
    localparam int SQ_IN_W   = 66;
    localparam int SQ_ROOT_W = 33;
    localparam int SQ_REM_W  = 37;
    localparam int SQ_ITERS  = 33;
    localparam int SQ_STEPS  = 3;

    // Divider: 64-bit dividend, 33-bit divisor, 31 quotient bits
    localparam int DIV_N_W   = 64;
    localparam int DIV_D_W   = 33;
    localparam int DIV_Q_W   = 31;
    localparam int DIV_STEPS = 3;

    // Sideband that rides along the square root pipeline
    typedef struct packed {
        logic [1:0]              cmd;
        logic [LANES-1:0][31:0]  anchor;
        logic [LANES-1:0]        neg;
        logic [LANES-1:0][31:0]  mag;
        logic [30:0]             t;
        logic [LANES-1:0][31:0]  gres;
        logic                    use_guess;
    } sq_side_t;

    // Sideband that rides along the divider pipeline
    typedef struct packed {
        logic [1:0]              cmd;
        logic [LANES-1:0][31:0]  anchor;
        logic [LANES-1:0]        neg;
        logic [LANES-1:0][31:0]  gres;
        logic                    use_guess;
        logic [31:0]             distance;
    } div_side_t;

    // One result item
    typedef struct packed {
        logic [1:0]  changed_var;
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic        ok;
    } res_t;

    localparam logic signed [49:0] S32_MAX_W = 50'sd2147483647;
    localparam logic signed [49:0] S32_MIN_W = -50'sd2147483648;

    // Saturate a wide signed value to the 32-bit signed range
    function automatic logic [31:0] sat32(input logic signed [49:0] v);
        if (v > S32_MAX_W) begin
            return 32'h7fff_ffff;
        end else if (v < S32_MIN_W) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/dcs_isqrt.sv]
// ----------------------------------------------------------------------------
// dcs_isqrt
// Pipelined floor square root, a few restoring iterations per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_isqrt import dcs_pkg::*; #(
    parameter int STEPS = SQ_STEPS,
    parameter int SB_W  = 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [SQ_IN_W-1:0]   in_x,
    input  wire logic [SB_W-1:0]      in_side,
    output logic                      out_valid,
    output logic [SQ_ROOT_W-1:0]      out_root,
    output logic [SB_W-1:0]           out_side
);

    localparam int NST = (SQ_ITERS + STEPS - 1) / STEPS;

    logic                 valid_reg [NST];
    logic [SQ_REM_W-1:0]  rem_reg   [NST];
    logic [SQ_ROOT_W-1:0] root_reg  [NST];
    logic [SQ_IN_W-1:0]   x_reg     [NST];
    logic [SB_W-1:0]      side_reg  [NST];

    genvar s;
    generate
        for (s = 0; s < NST; s++) begin : g_stage
            logic                 src_valid;
            logic [SQ_REM_W-1:0]  src_rem;
            logic [SQ_ROOT_W-1:0] src_root;
            logic [SQ_IN_W-1:0]   src_x;
            logic [SB_W-1:0]      src_side;
            logic [SQ_REM_W-1:0]  rem_next;
            logic [SQ_ROOT_W-1:0] root_next;
            logic [SQ_IN_W-1:0]   x_next;

            if (s == 0) begin : g_first
                assign src_valid = in_valid;
                assign src_rem   = '0;
                assign src_root  = '0;
                assign src_x     = in_x;
                assign src_side  = in_side;
            end else begin : g_later
                assign src_valid = valid_reg[s-1];
                assign src_rem   = rem_reg[s-1];
                assign src_root  = root_reg[s-1];
                assign src_x     = x_reg[s-1];
                assign src_side  = side_reg[s-1];
            end

            // Bring down the next bit pair and try the trial subtract
            always_comb begin
                rem_next  = src_rem;
                root_next = src_root;
                x_next    = src_x;
                for (int j = 0; j < STEPS; j++) begin
                    if (s * STEPS + j < SQ_ITERS) begin
                        rem_next = {rem_next[SQ_REM_W-3:0], x_next[SQ_IN_W-1 -: 2]};
                        x_next   = {x_next[SQ_IN_W-3:0], 2'b00};
                        if (rem_next >= {{(SQ_REM_W-SQ_ROOT_W-2){1'b0}}, root_next, 2'b01}) begin
                            rem_next  = rem_next
                                      - {{(SQ_REM_W-SQ_ROOT_W-2){1'b0}}, root_next, 2'b01};
                            root_next = {root_next[SQ_ROOT_W-2:0], 1'b1};
                        end else begin
                            root_next = {root_next[SQ_ROOT_W-2:0], 1'b0};
                        end
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[s] <= 1'b0;
                end else if (en) begin
                    valid_reg[s] <= src_valid;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s]  <= rem_next;
                    root_reg[s] <= root_next;
                    x_reg[s]    <= x_next;
                    side_reg[s] <= src_side;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NST-1];
    assign out_root  = root_reg[NST-1];
    assign out_side  = side_reg[NST-1];

endmodule

`default_nettype wire

[rtl/core/dcs_div.sv]
// ----------------------------------------------------------------------------
// dcs_div
// Pipelined restoring divider, three lanes sharing one divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_div import dcs_pkg::*; #(
    parameter int STEPS = DIV_STEPS,
    parameter int SB_W  = 1
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             en,
    input  wire logic                             in_valid,
    input  wire logic [LANES-1:0][DIV_N_W-1:0]    in_n,
    input  wire logic [DIV_D_W-1:0]               in_len,
    input  wire logic [SB_W-1:0]                  in_side,
    output logic                                  out_valid,
    output logic [LANES-1:0][DIV_Q_W-1:0]         out_q,
    output logic [SB_W-1:0]                       out_side
);

    localparam int NST = (DIV_Q_W + STEPS - 1) / STEPS;

    logic                             valid_reg [NST];
    logic [LANES-1:0][DIV_D_W-1:0]    rem_reg   [NST];
    logic [LANES-1:0][DIV_Q_W-1:0]    low_reg   [NST];
    logic [LANES-1:0][DIV_Q_W-1:0]    q_reg     [NST];
    logic [DIV_D_W-1:0]               len_reg   [NST];
    logic [SB_W-1:0]                  side_reg  [NST];

    genvar s;
    generate
        for (s = 0; s < NST; s++) begin : g_stage
            logic                          src_valid;
            logic [LANES-1:0][DIV_D_W-1:0] src_rem;
            logic [LANES-1:0][DIV_Q_W-1:0] src_low;
            logic [LANES-1:0][DIV_Q_W-1:0] src_q;
            logic [DIV_D_W-1:0]            src_len;
            logic [SB_W-1:0]               src_side;
            logic [LANES-1:0][DIV_D_W-1:0] rem_next;
            logic [LANES-1:0][DIV_Q_W-1:0] low_next;
            logic [LANES-1:0][DIV_Q_W-1:0] q_next;
            logic [DIV_D_W:0]              trial;

            if (s == 0) begin : g_first
                // Quotient fits in DIV_Q_W bits, so the top part is below the divisor
                always_comb begin
                    for (int l = 0; l < LANES; l++) begin
                        src_rem[l] = in_n[l][DIV_N_W-1 -: DIV_D_W];
                        src_low[l] = in_n[l][DIV_Q_W-1:0];
                    end
                end
                assign src_valid = in_valid;
                assign src_q     = '0;
                assign src_len   = in_len;
                assign src_side  = in_side;
            end else begin : g_later
                assign src_valid = valid_reg[s-1];
                assign src_rem   = rem_reg[s-1];
                assign src_low   = low_reg[s-1];
                assign src_q     = q_reg[s-1];
                assign src_len   = len_reg[s-1];
                assign src_side  = side_reg[s-1];
            end

            // Shift in one dividend bit and subtract the divisor when it fits
            always_comb begin
                rem_next = src_rem;
                low_next = src_low;
                q_next   = src_q;
                trial    = '0;
                for (int l = 0; l < LANES; l++) begin
                    for (int j = 0; j < STEPS; j++) begin
                        if (s * STEPS + j < DIV_Q_W) begin
                            trial       = {rem_next[l], low_next[l][DIV_Q_W-1]};
                            low_next[l] = {low_next[l][DIV_Q_W-2:0], 1'b0};
                            if (trial >= {1'b0, src_len}) begin
                                trial     = trial - {1'b0, src_len};
                                q_next[l] = {q_next[l][DIV_Q_W-2:0], 1'b1};
                            end else begin
                                q_next[l] = {q_next[l][DIV_Q_W-2:0], 1'b0};
                            end
                            rem_next[l] = trial[DIV_D_W-1:0];
                        end
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[s] <= 1'b0;
                end else if (en) begin
                    valid_reg[s] <= src_valid;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s]  <= rem_next;
                    low_reg[s]  <= low_next;
                    q_reg[s]    <= q_next;
                    len_reg[s]  <= src_len;
                    side_reg[s] <= src_side;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NST-1];
    assign out_q     = q_reg[NST-1];
    assign out_side  = side_reg[NST-1];

endmodule

`default_nettype wire

[rtl/core/distance_constraint_solve.sv]
// ----------------------------------------------------------------------------
// distance_constraint_solve
// Point-to-point distance constraint projection in Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Items pass stages 1 to 3, the square root, stages 4 and 5, the divider,
//   stage 6 and the output register. Throughput: one item per cycle while
//   the skid stage is empty; the square root and the divider are unrolled
//   into register stages, so no unit is shared between items.
// Reset clears all valid bits and the skid stage and loads the configuration
//   registers with their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_constraint_solve import dcs_pkg::*; #(
    parameter int SQ_STEPS_P  = SQ_STEPS,
    parameter int DIV_STEPS_P = DIV_STEPS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, target_distance
    input  wire logic [223:0]           s_tdata,
    // cmd
    input  wire logic [1:0]             s_tuser,
    // result items
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // out_x, out_y, out_z, ok, zero fill
    output logic [103:0]                m_tdata,
    // changed_var
    output logic [1:0]                  m_tuser
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LANES-1:0][31:0] guess_reg;
    logic [30:0]            min_dist_reg;
    logic [62:0]            epsilon_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guess_reg[0] <= 32'h0001_0000;
            guess_reg[1] <= '0;
            guess_reg[2] <= '0;
            min_dist_reg <= '0;
            epsilon_reg  <= 63'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GUESS_X:  guess_reg[0] <= cfg_wdata[31:0];
                REG_GUESS_Y:  guess_reg[1] <= cfg_wdata[31:0];
                REG_GUESS_Z:  guess_reg[2] <= cfg_wdata[31:0];
                REG_MIN_DIST: min_dist_reg <= cfg_wdata[30:0];
                REG_EPSILON:  epsilon_reg  <= cfg_wdata[62:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline advances while the skid stage is free
    logic skid_valid_reg;
    logic en;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: pick anchor, form difference magnitudes and clamp target
    // ------------------------------------------------------------------
    logic                   v1_reg;
    logic [1:0]             cmd1_reg;
    logic [LANES-1:0][31:0] anc1_reg, mag1_reg;
    logic [LANES-1:0]       neg1_reg;
    logic [30:0]            t1_reg;

    logic [LANES-1:0][31:0] anc1_next, mag1_next, mov1;
    logic [LANES-1:0][32:0] d1, dn1;
    logic [LANES-1:0]       neg1_next;
    logic [31:0]            tgt;
    logic [30:0]            t1_next;

    assign tgt = s_tdata[223:192];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (s_tuser == CMD_MOVE_SECOND) begin
                anc1_next[i] = s_tdata[32*i +: 32];
                mov1[i]      = s_tdata[96+32*i +: 32];
            end else begin
                anc1_next[i] = s_tdata[96+32*i +: 32];
                mov1[i]      = s_tdata[32*i +: 32];
            end
            d1[i]        = {mov1[i][31], mov1[i]} - {anc1_next[i][31], anc1_next[i]};
            dn1[i]       = ~d1[i] + 33'd1;
            neg1_next[i] = d1[i][32];
            mag1_next[i] = d1[i][32] ? dn1[i][31:0] : d1[i][31:0];
        end
        if ($signed(tgt) < $signed({1'b0, min_dist_reg})) begin
            t1_next = min_dist_reg;
        end else begin
            t1_next = tgt[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd1_reg <= s_tuser;
            anc1_reg <= anc1_next;
            mag1_reg <= mag1_next;
            neg1_reg <= neg1_next;
            t1_reg   <= t1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares of the differences and default direction products
    // ------------------------------------------------------------------
    logic                   v2_reg;
    logic [1:0]             cmd2_reg;
    logic [LANES-1:0][31:0] anc2_reg, mag2_reg;
    logic [LANES-1:0]       neg2_reg, gneg2_reg;
    logic [30:0]            t2_reg;
    logic [LANES-1:0][63:0] sq2_reg;
    logic [LANES-1:0][62:0] gprod2_reg;

    logic [LANES-1:0][31:0] gmag, gneg_val;
    logic [LANES-1:0][63:0] sq2_next;
    logic [LANES-1:0][62:0] gprod2_next;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            gneg_val[i]    = ~guess_reg[i] + 32'd1;
            gmag[i]        = guess_reg[i][31] ? gneg_val[i] : guess_reg[i];
            sq2_next[i]    = 64'(mag1_reg[i]) * 64'(mag1_reg[i]);
            gprod2_next[i] = 63'(gmag[i]) * 63'(t1_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd2_reg   <= cmd1_reg;
            anc2_reg   <= anc1_reg;
            mag2_reg   <= mag1_reg;
            neg2_reg   <= neg1_reg;
            t2_reg     <= t1_reg;
            sq2_reg    <= sq2_next;
            gprod2_reg <= gprod2_next;
            for (int i = 0; i < LANES; i++) begin
                gneg2_reg[i] <= guess_reg[i][31];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared length and finished default direction results
    // ------------------------------------------------------------------
    logic                   v3_reg;
    logic [1:0]             cmd3_reg;
    logic [LANES-1:0][31:0] anc3_reg, mag3_reg, gres3_reg;
    logic [LANES-1:0]       neg3_reg;
    logic [30:0]            t3_reg;
    logic [SQ_IN_W-1:0]     l2_3_reg;

    logic [SQ_IN_W-1:0]     l2_next;
    logic [LANES-1:0][63:0] goff_r;
    logic [LANES-1:0][49:0] gsum;
    logic [LANES-1:0][31:0] gres3_next;

    always_comb begin
        l2_next = SQ_IN_W'(sq2_reg[0]) + SQ_IN_W'(sq2_reg[1]) + SQ_IN_W'(sq2_reg[2]);
        for (int i = 0; i < LANES; i++) begin
            // round half away from zero on the magnitude, then apply sign
            goff_r[i] = 64'(gprod2_reg[i]) + 64'd32768;
            if (gneg2_reg[i]) begin
                gsum[i] = {{18{anc2_reg[i][31]}}, anc2_reg[i]} - {2'b00, goff_r[i][63:16]};
            end else begin
                gsum[i] = {{18{anc2_reg[i][31]}}, anc2_reg[i]} + {2'b00, goff_r[i][63:16]};
            end
            gres3_next[i] = sat32(gsum[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd3_reg  <= cmd2_reg;
            anc3_reg  <= anc2_reg;
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            t3_reg    <= t2_reg;
            l2_3_reg  <= l2_next;
            gres3_reg <= gres3_next;
        end
    end

    // ------------------------------------------------------------------
    // Square root of the squared length
    // ------------------------------------------------------------------
    sq_side_t               sqs_in, sqs_out;
    logic                   sq_valid;
    logic [SQ_ROOT_W-1:0]   sq_root;

    always_comb begin
        sqs_in.cmd       = cmd3_reg;
        sqs_in.anchor    = anc3_reg;
        sqs_in.neg       = neg3_reg;
        sqs_in.mag       = mag3_reg;
        sqs_in.t         = t3_reg;
        sqs_in.gres      = gres3_reg;
        // coincident points take the default direction even at zero epsilon
        sqs_in.use_guess = (l2_3_reg < {3'b000, epsilon_reg}) || (l2_3_reg == '0);
    end

    dcs_isqrt #(
        .STEPS (SQ_STEPS_P),
        .SB_W  ($bits(sq_side_t))
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_x      (l2_3_reg),
        .in_side   (sqs_in),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sqs_out)
    );

    // ------------------------------------------------------------------
    // Stage 4: clamped distance and scaled difference products
    // ------------------------------------------------------------------
    logic                   v4_reg;
    div_side_t              ds4_reg;
    logic [SQ_ROOT_W-1:0]   len4_reg;
    logic [LANES-1:0][62:0] prod4_reg;

    div_side_t              ds4_next;
    logic [SQ_ROOT_W-1:0]   lenc;
    logic [LANES-1:0][62:0] prod4_next;

    always_comb begin
        lenc = (sq_root < {2'b00, min_dist_reg}) ? {2'b00, min_dist_reg} : sq_root;
        ds4_next.cmd       = sqs_out.cmd;
        ds4_next.anchor    = sqs_out.anchor;
        ds4_next.neg       = sqs_out.neg;
        ds4_next.gres      = sqs_out.gres;
        ds4_next.use_guess = sqs_out.use_guess;
        ds4_next.distance  = (lenc > 33'h0_7fff_ffff) ? 32'h7fff_ffff : lenc[31:0];
        for (int i = 0; i < LANES; i++) begin
            prod4_next[i] = 63'(sqs_out.mag[i]) * 63'(sqs_out.t);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ds4_reg   <= ds4_next;
            len4_reg  <= sq_root;
            prod4_reg <= prod4_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: add half the divisor for rounding
    // ------------------------------------------------------------------
    logic                          v5_reg;
    div_side_t                     ds5_reg;
    logic [SQ_ROOT_W-1:0]          len5_reg;
    logic [LANES-1:0][DIV_N_W-1:0] n5_reg;

    logic [LANES-1:0][DIV_N_W-1:0] n5_next;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n5_next[i] = DIV_N_W'(prod4_reg[i]) + DIV_N_W'(len4_reg[SQ_ROOT_W-1:1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ds5_reg  <= ds4_reg;
            len5_reg <= len4_reg;
            n5_reg   <= n5_next;
        end
    end

    // ------------------------------------------------------------------
    // Divide by the length
    // ------------------------------------------------------------------
    logic                          dv_valid;
    logic [LANES-1:0][DIV_Q_W-1:0] dv_q;
    div_side_t                     dvs_out;

    dcs_div #(
        .STEPS (DIV_STEPS_P),
        .SB_W  ($bits(div_side_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .in_n      (n5_reg),
        .in_len    (len5_reg),
        .in_side   (ds5_reg),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_side  (dvs_out)
    );

    // ------------------------------------------------------------------
    // Stage 6: offset the anchor and select the result by command
    // ------------------------------------------------------------------
    logic                   p_valid_reg;
    res_t                   p_reg;

    res_t                   p_next;
    logic [LANES-1:0][49:0] nsum;
    logic [LANES-1:0][31:0] npt, sel;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (dvs_out.neg[i]) begin
                nsum[i] = {{18{dvs_out.anchor[i][31]}}, dvs_out.anchor[i]}
                        - {19'd0, dv_q[i]};
            end else begin
                nsum[i] = {{18{dvs_out.anchor[i][31]}}, dvs_out.anchor[i]}
                        + {19'd0, dv_q[i]};
            end
            npt[i] = sat32(nsum[i]);
            sel[i] = dvs_out.use_guess ? dvs_out.gres[i] : npt[i];
        end
        unique case (dvs_out.cmd)
            CMD_MOVE_FIRST: begin
                p_next = '{changed_var: VAR_FIRST, out_x: sel[0], out_y: sel[1],
                           out_z: sel[2], ok: 1'b1};
            end
            CMD_MOVE_SECOND: begin
                p_next = '{changed_var: VAR_SECOND, out_x: sel[0], out_y: sel[1],
                           out_z: sel[2], ok: 1'b1};
            end
            CMD_DISTANCE: begin
                p_next = '{changed_var: VAR_DISTANCE, out_x: dvs_out.distance, out_y: 32'd0,
                           out_z: 32'd0, ok: 1'b1};
            end
            CMD_INVALID: begin
                p_next = '{changed_var: VAR_FIRST, out_x: 32'd0, out_y: 32'd0,
                           out_z: 32'd0, ok: 1'b0};
            end
            default: begin
                p_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid stage
    // ------------------------------------------------------------------
    logic out_valid_reg;
    res_t out_reg, skid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            // drain the skid first; the pipeline is held while it is full
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= p_valid_reg;
            end
        end else if (en && p_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : p_reg;
        end else if (en && p_valid_reg) begin
            skid_reg <= p_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.ok, out_reg.out_z, out_reg.out_y, out_reg.out_x};
    assign m_tuser  = out_reg.changed_var;

endmodule

`default_nettype wire

[tb/tb_distance_constraint_solve.sv]
// ----------------------------------------------------------------------------
// tb_distance_constraint_solve
// Self-checking bench for the Q16.16 point distance constraint solver.
// A short table of directed items is followed by random items over several
// register settings. Each accepted item is predicted in the bench and the
// predictions are matched in order against the result stream. Both stream
// sides idle at random, and the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_distance_constraint_solve;
    import dcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
    localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam int SETTLE = 40;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [223:0]          s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [103:0]          m_tdata;
    logic [1:0]            m_tuser;

    distance_constraint_solve u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // bench copy of the configuration
    logic [2:0][31:0] dir_q = {32'd0, 32'd0, Q_ONE};
    logic [30:0]      min_dist_q = '0;
    logic [62:0]      eps_q = 63'd1;

    res_t  solved_q[$];
    int    mismatches = 0;
    bit    rx_calm = 1'b0;
    int    rx_hold = 0;
    bit    row_fixed = 1'b0;
    res_t  row_result;

    // floor square root of a 66-bit value
    function automatic logic [32:0] root66(logic [65:0] v);
        logic [69:0] rem;
        logic [33:0] root;
        logic [69:0] trial;
        rem = '0;
        root = '0;
        for (int k = 32; k >= 0; k--) begin
            rem = (rem << 2) | ((v >> (2 * k)) & 66'd3);
            trial = {root, 2'b01};
            if (rem >= trial) begin
                rem = rem - trial;
                root = {root[32:0], 1'b1};
            end else begin
                root = {root[32:0], 1'b0};
            end
        end
        return root[32:0];
    endfunction

    // squared length of b - a, exact
    function automatic logic [65:0] span_sq(logic [2:0][31:0] a, logic [2:0][31:0] b);
        logic signed [33:0] d;
        logic [32:0]        m;
        logic [65:0]        acc;
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            d = $signed({{2{b[i][31]}}, b[i]}) - $signed({{2{a[i][31]}}, a[i]});
            m = d < 0 ? 33'(-d) : 33'(d);
            acc = acc + 66'(m) * 66'(m);
        end
        return acc;
    endfunction

    function automatic logic [31:0] clip32(logic signed [79:0] v);
        if (v > $signed(80'h7fff_ffff)) return Q_MAX;
        if (v < -$signed(80'h8000_0000)) return Q_MIN;
        return v[31:0];
    endfunction

    // place the moved point on the ray from the anchor at distance t, or at t times the default direction
    function automatic logic [2:0][31:0] place(logic [2:0][31:0] anchor,
                                              logic [2:0][31:0] moved, logic [30:0] t);
        logic [2:0][31:0]   pt;
        logic [65:0]        l2;
        logic [32:0]        len;
        logic               along_dir;
        logic signed [33:0] d;
        logic [32:0]        m;
        logic [64:0]        prod;
        logic [64:0]        q;
        logic               neg;
        logic signed [79:0] off;
        l2 = span_sq(anchor, moved);
        len = root66(l2);
        along_dir = (l2 < 66'(eps_q)) || (l2 == 0);
        for (int i = 0; i < 3; i++) begin
            if (along_dir) begin
                d = $signed({{2{dir_q[i][31]}}, dir_q[i]});
            end else begin
                d = $signed({{2{moved[i][31]}}, moved[i]})
                    - $signed({{2{anchor[i][31]}}, anchor[i]});
            end
            neg = d < 0;
            m = neg ? 33'(-d) : 33'(d);
            prod = 65'(m) * 65'(t);
            if (along_dir) q = (prod + 65'd32768) >> 16;
            else q = (prod + 65'(len >> 1)) / 65'(len);
            off = neg ? -$signed({15'd0, q}) : $signed({15'd0, q});
            pt[i] = clip32($signed({{48{anchor[i][31]}}, anchor[i]}) + off);
        end
        return pt;
    endfunction

    function automatic res_t solve_item(logic [1:0] cmd, logic [223:0] data);
        logic [2:0][31:0] pa;
        logic [2:0][31:0] pb;
        logic [2:0][31:0] pt;
        logic [31:0]      tgt;
        logic [30:0]      t;
        logic [32:0]      len;
        res_t             r;
        pa = data[95:0];
        pb = data[191:96];
        tgt = data[223:192];
        t = ($signed(tgt) < $signed({1'b0, min_dist_q})) ? min_dist_q : tgt[30:0];
        r = '0;
        case (cmd)
            CMD_MOVE_FIRST: begin
                pt = place(pb, pa, t);
                r = '{VAR_FIRST, pt[0], pt[1], pt[2], 1'b1};
            end
            CMD_MOVE_SECOND: begin
                pt = place(pa, pb, t);
                r = '{VAR_SECOND, pt[0], pt[1], pt[2], 1'b1};
            end
            CMD_DISTANCE: begin
                len = root66(span_sq(pa, pb));
                if (len < 33'(min_dist_q)) len = 33'(min_dist_q);
                if (len > 33'(Q_MAX)) len = 33'(Q_MAX);
                r = '{VAR_DISTANCE, len[31:0], 32'd0, 32'd0, 1'b1};
            end
            default: r = '{VAR_FIRST, 32'd0, 32'd0, 32'd0, 1'b0};
        endcase
        return r;
    endfunction

    // record the prediction for each accepted item, check each result
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && s_tvalid && s_tready) begin
            solved_q.push_back(row_fixed ? row_result : solve_item(s_tuser, s_tdata));
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[96]};
            if (solved_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = solved_q.pop_front();
                if (got.changed_var !== want.changed_var || got.out_x !== want.out_x ||
                    got.out_y !== want.out_y || got.out_z !== want.out_z ||
                    got.ok !== want.ok) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: var %0d/%0d x %h/%h y %h/%h z %h/%h ok %b/%b",
                                 want.changed_var, got.changed_var, want.out_x, got.out_x,
                                 want.out_y, got.out_y, want.out_z, got.out_z,
                                 want.ok, got.ok);
                    end
                end
            end
        end
    end

    // receiver: random stalls, calm stretch, long hold-off
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= rx_calm || ($urandom_range(99) >= 19);
        end
    end

    initial begin
        #20ms;
        $display("[distance_constraint_solve] ERROR");
        $finish;
    end

    // drop valid, wait for the pipeline to drain, then let it settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (solved_q.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [62:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_GUESS_X: dir_q[0] = val[31:0];
            REG_GUESS_Y: dir_q[1] = val[31:0];
            REG_GUESS_Z: dir_q[2] = val[31:0];
            REG_MIN_DIST: min_dist_q = val[30:0];
            REG_EPSILON: eps_q = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // offer one item, with a random gap first, hold until accepted;
    // valid stays up so the next item can follow at once
    task automatic send_item(logic [1:0] cmd, logic [223:0] data, bit fixed, res_t r);
        @(negedge aclk);
        while (!rx_calm && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= data;
        row_fixed <= fixed;
        row_result <= r;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2, 3, 4: return $urandom;
            default: return 32'($signed($urandom_range(20 * 65536)) - 10 * 65536);
        endcase
    endfunction

    function automatic logic [223:0] pack_pts(logic [31:0] ax, logic [31:0] ay,
                                              logic [31:0] az, logic [31:0] bx,
                                              logic [31:0] by, logic [31:0] bz,
                                              logic [31:0] t);
        return {t, bz, by, bx, az, ay, ax};
    endfunction

    typedef struct {
        logic [1:0]   cmd;
        logic [223:0] data;
        bit           fixed;
        res_t         r;
    } row_t;

    row_t rows[$];
    res_t unknown = '0;

    initial begin
        logic [1:0]   cmd;
        logic [223:0] data;
        logic [31:0]  ax, ay, az, bx, by, bz, t;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows; expectations typed in where obvious
        rows.push_back('{CMD_INVALID, pack_pts(Q_MAX, 1, 2, 3, 4, 5, 6), 1,
                         '{VAR_FIRST, 32'd0, 32'd0, 32'd0, 1'b0}});
        rows.push_back('{CMD_DISTANCE, pack_pts(7, 7, 7, 7, 7, 7, 0), 1,
                         '{VAR_DISTANCE, 32'd0, 32'd0, 32'd0, 1'b1}});
        rows.push_back('{CMD_MOVE_FIRST, pack_pts(5, 5, 5, 5, 5, 5, Q_ONE), 1,
                         '{VAR_FIRST, 32'd65541, 32'd5, 32'd5, 1'b1}});
        rows.push_back('{CMD_MOVE_SECOND, pack_pts(0, 0, 0, 0, 0, 0, Q_ONE), 1,
                         '{VAR_SECOND, Q_ONE, 32'd0, 32'd0, 1'b1}});
        rows.push_back('{CMD_DISTANCE, pack_pts(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 0), 1,
                         '{VAR_DISTANCE, Q_MAX, 32'd0, 32'd0, 1'b1}});
        rows.push_back('{CMD_MOVE_SECOND, pack_pts(Q_MAX, 0, 0, Q_MAX, 0, 0, Q_MAX), 1,
                         '{VAR_SECOND, Q_MAX, 32'd0, 32'd0, 1'b1}});
        rows.push_back('{CMD_MOVE_FIRST, pack_pts(Q_MIN, 0, 0, Q_MAX, 0, 0, Q_MAX), 0, unknown});
        rows.push_back('{CMD_MOVE_SECOND, pack_pts(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX,
                         Q_MAX), 0, unknown});
        rows.push_back('{CMD_MOVE_FIRST, pack_pts(3 * 65536, 4 * 65536, 0, 0, 0, 0, 10 * 65536),
                         0, unknown});
        rows.push_back('{CMD_MOVE_SECOND, pack_pts(0, 0, 0, 1, 0, 0, Q_MIN), 0, unknown});
        rows.push_back('{CMD_DISTANCE, pack_pts(0, 0, 0, 3 * 65536, 4 * 65536, 0, 0), 0,
                         unknown});
        rows.push_back('{CMD_MOVE_FIRST, pack_pts(1, 0, 0, 0, 0, 0, 32'hffff_0000), 0, unknown});
        rows.push_back('{CMD_INVALID, pack_pts(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN),
                         1, '{VAR_FIRST, 32'd0, 32'd0, 32'd0, 1'b0}});
        foreach (rows[i]) send_item(rows[i].cmd, rows[i].data, rows[i].fixed, rows[i].r);

        // coincident points with zero epsilon, min clamp on distance
        drain();
        write_reg(REG_EPSILON, 63'd0);
        write_reg(REG_MIN_DIST, 63'h7fff_ffff);
        write_reg(REG_UNUSED, 63'h7fff_ffff_ffff_ffff);
        send_item(CMD_MOVE_FIRST, pack_pts(9, 9, 9, 9, 9, 9, 0), 0, unknown);
        send_item(CMD_DISTANCE, pack_pts(9, 9, 9, 9, 9, 9, 0), 1,
                  '{VAR_DISTANCE, Q_MAX, 32'd0, 32'd0, 1'b1});

        // random phases over a range of register settings
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(REG_GUESS_X, 63'(Q_MIN));
                    write_reg(REG_GUESS_Y, 63'(Q_MAX));
                    write_reg(REG_GUESS_Z, 63'(Q_ONE));
                    write_reg(REG_MIN_DIST, 63'd0);
                    write_reg(REG_EPSILON, 63'h7fff_ffff_ffff_ffff);
                end
                1: write_reg(REG_EPSILON, 63'd1 << 40);
                2: begin
                    write_reg(REG_GUESS_X, 63'($urandom));
                    write_reg(REG_GUESS_Y, {31'h7fff_ffff, 32'($urandom)});
                    write_reg(REG_GUESS_Z, 63'(-32'sd40000));
                    write_reg(REG_MIN_DIST, 63'h0002_0000);
                end
                3: write_reg(REG_EPSILON, 63'd0);
                4: write_reg(REG_MIN_DIST, 63'h7fff_ffff);
                5: begin
                    write_reg(REG_MIN_DIST, 63'(31'($urandom)));
                    write_reg(REG_EPSILON, {31'($urandom), 32'($urandom)});
                end
                6: begin
                    write_reg(REG_GUESS_X, 63'd0);
                    write_reg(REG_GUESS_Y, 63'd0);
                    write_reg(REG_GUESS_Z, 63'd0);
                    write_reg(REG_EPSILON, 63'd1 << 34);
                end
                default: write_reg(REG_MIN_DIST, 63'd0);
            endcase
            rx_calm = (ph == 3);
            for (int n = 0; n < 200; n++) begin
                // long receiver hold-off while items keep coming
                if (ph == 1 && n == 20) rx_hold = 300;
                // pause the sender until every result is back
                if (ph == 5 && n == 100) drain();
                cmd = 2'($urandom_range(3));
                ax = rand_coord(); ay = rand_coord(); az = rand_coord();
                case ($urandom_range(5))
                    0: begin bx = ax; by = ay; bz = az; end
                    1: begin
                        bx = ax + 32'($signed($urandom_range(8)) - 4);
                        by = ay + 32'($signed($urandom_range(8)) - 4);
                        bz = az;
                    end
                    default: begin bx = rand_coord(); by = rand_coord(); bz = rand_coord(); end
                endcase
                case ($urandom_range(3))
                    0: t = $urandom;
                    1: t = 32'($urandom_range(0, 8 * 65536));
                    2: t = Q_MAX;
                    default: t = 32'(-$signed(32'($urandom_range(65536))));
                endcase
                data = pack_pts(ax, ay, az, bx, by, bz, t);
                send_item(cmd, data, 0, unknown);
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("[distance_constraint_solve] OK");
        end else begin
            $display("[distance_constraint_solve] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
